>>> hw/rtl/idll_pkg.sv
`timescale 1ns / 1ps

package idll_pkg;

  localparam int NODE_W     = 10;
  localparam int NODE_SLOTS = 1 << NODE_W;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [1:0]        func_t;

  localparam func_t FUNC_UNLINK       = 2'd0;
  localparam func_t FUNC_INSERT_BEFORE = 2'd1;
  localparam func_t FUNC_INSERT_AFTER = 2'd2;
  localparam func_t FUNC_QUERY        = 2'd3;

  typedef struct packed {
    logic  we;
    node_t addr;
    node_t data;
  } link_wr_t;

  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  clr_busy;
  } link_ctl_t;

endpackage

>>> hw/rtl/idll_if.sv
`timescale 1ns / 1ps

interface idll_req_if;
  import idll_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  node_t node_i;
  node_t node_j;

  modport source (output valid, output func, output node_i, output node_j, input ready);
  modport sink   (input valid, input func, input node_i, input node_j, output ready);
endinterface

interface idll_rsp_if;
  import idll_pkg::*;

  logic  valid;
  logic  ready;
  node_t prev_node;
  node_t next_node;

  modport source (output valid, output prev_node, output next_node, input ready);
  modport sink   (input valid, input prev_node, input next_node, output ready);
endinterface

>>> hw/rtl/indexed_doubly_linked_list_top.sv
`timescale 1ns / 1ps
// Indexed doubly linked list over 1024 numbered nodes; node 0 means none.
// in_req carries one transaction per request: func (unlink, insert before,
// insert after, query), node_i and node_j. Only a query yields a
// transaction on out_rsp, carrying prev_node and next_node of node_i.
// Both link tables sit in single-port-write synchronous RAMs with a
// registered read port. A request reads node_i's links on the accept edge.
// Updates then run through the write steps of ST_WR, at most one table
// write per RAM per cycle, applied in the order of the list algorithm;
// in_req.ready stays low until they end. A query passes through ST_RSP,
// where its result is loaded once the output register is free.
// After reset both tables are cleared by a pass over all 1024 entries,
// one entry per cycle; in_req.ready stays low until it ends.
// The result sits in an output register: while out_rsp.ready is low the
// block still accepts updates, and a second query waits for the register
// to be free.
module indexed_doubly_linked_list_top (
  input logic        clk,
  input logic        rst_n,
  idll_req_if.sink   in_req,
  idll_rsp_if.source out_rsp
);
  import idll_pkg::*;

  link_wr_t  prev_wr, next_wr;
  link_ctl_t ctl;
  node_t     prev_rd, next_rd;

  idll_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_req),
    .rsp     (out_rsp),
    .prev_rd (prev_rd),
    .next_rd (next_rd),
    .prev_wr (prev_wr),
    .next_wr (next_wr),
    .ctl     (ctl)
  );

  idll_link_ram u_prev_ram (
    .clk     (clk),
    .wr      (prev_wr),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (prev_rd)
  );

  idll_link_ram u_next_ram (
    .clk     (clk),
    .wr      (next_wr),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (next_rd)
  );

  a_no_rd_during_wr: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_en |-> (!prev_wr.we && !next_wr.we))
    else $error("link read overlaps a link write");

  a_null_entry_kept: assert property (@(posedge clk) disable iff (!rst_n)
    ((prev_wr.we && prev_wr.addr == '0) || (next_wr.we && next_wr.addr == '0))
      |-> ctl.clr_busy)
    else $error("entry of node zero written outside clearing pass");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(ctl.clr_busy) |-> ($past(prev_wr.addr) == '1 && $past(next_wr.we)))
    else $error("clearing pass ended early");

  a_no_rd_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr_busy |-> !ctl.rd_en)
    else $error("request accepted during clearing pass");

endmodule

>>> hw/rtl/idll_link_ram.sv
`timescale 1ns / 1ps

module idll_link_ram (
  input  logic              clk,
  input  idll_pkg::link_wr_t wr,
  input  logic              rd_en,
  input  idll_pkg::node_t   rd_addr,
  output idll_pkg::node_t   rd_data
);
  import idll_pkg::*;

  node_t mem_r [NODE_SLOTS];
  node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/idll_ctrl.sv
`timescale 1ns / 1ps

module idll_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  idll_req_if.sink           req,
  idll_rsp_if.source         rsp,
  input  idll_pkg::node_t    prev_rd,
  input  idll_pkg::node_t    next_rd,
  output idll_pkg::link_wr_t prev_wr,
  output idll_pkg::link_wr_t next_wr,
  output idll_pkg::link_ctl_t ctl
);
  import idll_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_WR   = 4'b0100,
    ST_RSP  = 4'b1000
  } state_t;

  localparam logic [1:0] LAST_STEP = 2'd2;
  localparam node_t      NONE      = '0;
  localparam node_t      CLR_LAST  = '1;

  state_t     state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  node_t      clr_cnt_r, clr_cnt_nxt;
  func_t      func_r;
  node_t      i_r, j_r;
  logic       out_valid_r, out_valid_nxt;
  node_t      out_prev_r, out_next_r;

  logic     accept;
  logic     load_out;
  logic     has_p, has_n, i_ok, j_ok;
  link_wr_t pw, nw;

  function automatic link_wr_t wr_op(node_t a, node_t d);
    link_wr_t w;
    w.we   = 1'b1;
    w.addr = a;
    w.data = d;
    return w;
  endfunction

  assign req.ready = (state_r == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign load_out  = (state_r == ST_RSP) && (!out_valid_r || rsp.ready);

  assign has_p = (prev_rd != NONE);
  assign has_n = (next_rd != NONE);
  assign i_ok  = (i_r != NONE);
  assign j_ok  = (j_r != NONE);

  always_comb begin
    pw = '0;
    nw = '0;
    case (state_r)
      ST_CLR: begin
        pw = wr_op(clr_cnt_r, NONE);
        nw = wr_op(clr_cnt_r, NONE);
      end
      ST_WR: begin
        case (func_r)
          FUNC_UNLINK: begin
            if (i_ok && has_p && has_n) begin
              case (step_r)
                2'd0: begin
                  nw = wr_op(prev_rd, NONE);
                  pw = wr_op(i_r, NONE);
                end
                2'd1: begin
                  nw = wr_op(i_r, NONE);
                  pw = wr_op(next_rd, NONE);
                end
                default: begin
                  nw = wr_op(prev_rd, next_rd);
                  pw = wr_op(next_rd, prev_rd);
                end
              endcase
            end else if (i_ok && has_p && step_r == 2'd0) begin
              nw = wr_op(prev_rd, NONE);
              pw = wr_op(i_r, NONE);
            end else if (i_ok && has_n && step_r == 2'd0) begin
              nw = wr_op(i_r, NONE);
              pw = wr_op(next_rd, NONE);
            end
          end
          FUNC_INSERT_BEFORE: begin
            if (i_ok && j_ok && has_p) begin
              case (step_r)
                2'd0: begin
                  nw = wr_op(prev_rd, NONE);
                  pw = wr_op(i_r, NONE);
                end
                2'd1: begin
                  nw = wr_op(prev_rd, j_r);
                  pw = wr_op(j_r, prev_rd);
                end
                default: begin
                  nw = wr_op(j_r, i_r);
                  pw = wr_op(i_r, j_r);
                end
              endcase
            end else if (i_ok && j_ok && step_r == 2'd0) begin
              nw = wr_op(j_r, i_r);
              pw = wr_op(i_r, j_r);
            end
          end
          FUNC_INSERT_AFTER: begin
            if (i_ok && j_ok && has_n) begin
              case (step_r)
                2'd0: begin
                  nw = wr_op(i_r, NONE);
                  pw = wr_op(next_rd, NONE);
                end
                2'd1: begin
                  nw = wr_op(i_r, j_r);
                  pw = wr_op(j_r, i_r);
                end
                default: begin
                  nw = wr_op(j_r, next_rd);
                  pw = wr_op(next_rd, j_r);
                end
              endcase
            end else if (i_ok && j_ok && step_r == 2'd0) begin
              nw = wr_op(i_r, j_r);
              pw = wr_op(j_r, i_r);
            end
          end
          default: begin
            pw = '0;
            nw = '0;
          end
        endcase
      end
      default: begin
        pw = '0;
        nw = '0;
      end
    endcase
  end

  assign prev_wr = pw;
  assign next_wr = nw;

  assign ctl.rd_en    = accept;
  assign ctl.rd_addr  = req.node_i;
  assign ctl.clr_busy = (state_r == ST_CLR);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    if (rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + node_t'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_nxt = 2'd0;
        if (accept) begin
          state_nxt = (req.func == FUNC_QUERY) ? ST_RSP : ST_WR;
        end
      end
      ST_WR: begin
        step_nxt = step_r + 2'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RSP: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      step_r      <= 2'd0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= req.func;
      i_r    <= req.node_i;
      j_r    <= req.node_j;
    end
    if (load_out) begin
      out_prev_r <= prev_rd;
      out_next_r <= next_rd;
    end
  end

  assign rsp.valid     = out_valid_r;
  assign rsp.prev_node = out_prev_r;
  assign rsp.next_node = out_next_r;

endmodule
